>>> src/assert_macros.svh
// assertion macros used by the ring controller rtl (brpr_ctrl)
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define BRPR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked at every clock edge, reset included
`define BRPR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/brpr_pkg.sv
// types and constants of the block ring controller
package brpr_pkg;

  // default ring capacity
  localparam int MAX_BLOCKS_DEF = 64;

  // register reset values
  localparam logic [6:0]  BLOCK_COUNT_RST = 7'd64;
  localparam logic [15:0] BLOCK_SIZE_RST  = 16'd512;

  // level event threshold divisor
  localparam int HALF_DIV = 2;

  // configuration register indexes
  localparam logic CFG_BLOCK_COUNT = 1'b0;
  localparam logic CFG_BLOCK_SIZE  = 1'b1;

  typedef enum logic [2:0] {
    OP_PUSH    = 3'd0,
    OP_POP     = 3'd1,
    OP_PEEK    = 3'd2,
    OP_UNPEEK  = 3'd3,
    OP_CONSUME = 3'd4,
    OP_RESERVE = 3'd5,
    OP_COMMIT  = 3'd6,
    OP_RELEASE = 3'd7
  } op_e;

  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_OVERFLOW  = 3'd1,
    EV_UNDERFLOW = 3'd2,
    EV_HALF      = 3'd3,
    EV_EMPTY     = 3'd4,
    EV_FULL      = 3'd5
  } ev_e;

  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] size;
  } in_word_t;

  typedef struct packed {
    logic       ok;
    logic [5:0] slot;
    logic       null_block;
    logic [2:0] event_res;
    logic [6:0] used_count;
  } out_word_t;

  typedef struct packed {
    logic [6:0]  block_count;
    logic [15:0] block_size;
  } cfg_t;

endpackage

>>> src/brpr_ctrl.sv
// ring pointers, counts and per-operation result logic
`include "assert_macros.svh"

module brpr_ctrl #(
  parameter int MAX_BLOCKS = brpr_pkg::MAX_BLOCKS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  brpr_pkg::in_word_t   in_word,
  input  brpr_pkg::cfg_t       cfg,
  output brpr_pkg::out_word_t  res
);

  localparam int PTR_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int CMP_W = ((CNT_W > 7) ? CNT_W : 7) + 1;

  logic [PTR_W-1:0] read_ptr_r, read_ptr_nxt;
  logic [PTR_W-1:0] write_ptr_r, write_ptr_nxt;
  logic [PTR_W-1:0] peek_ptr_r, peek_ptr_nxt;
  logic [PTR_W-1:0] reserve_ptr_r, reserve_ptr_nxt;
  logic [CNT_W-1:0] used_r, used_nxt;
  logic [CNT_W-1:0] peeked_r, peeked_nxt;
  logic [CNT_W-1:0] reserved_r, reserved_nxt;

  logic [CMP_W-1:0] n_len;
  logic [CMP_W-1:0] bc_ext;
  logic [CMP_W-1:0] used_ext;
  logic [CMP_W-1:0] peeked_ext;
  logic [CMP_W-1:0] reserved_ext;
  logic [CMP_W-1:0] slot_ext;
  logic [CMP_W-1:0] used_out_ext;
  logic             size_ok;
  brpr_pkg::op_e    op;
  brpr_pkg::ev_e    ev;
  logic [PTR_W-1:0] slot_sel;
  logic             res_ok;
  logic             res_nb;
  logic             push_ok;

  // effective ring length, clamped to 1..MAX_BLOCKS
  assign bc_ext = CMP_W'(cfg.block_count);
  always_comb begin
    if (bc_ext == '0) begin
      n_len = CMP_W'(1);
    end else if (bc_ext > CMP_W'(MAX_BLOCKS)) begin
      n_len = CMP_W'(MAX_BLOCKS);
    end else begin
      n_len = bc_ext;
    end
  end

  // pointer advance with wrap at the ring length
  function automatic logic [PTR_W-1:0] adv(input logic [PTR_W-1:0] p,
                                          input logic [CMP_W-1:0] len);
    logic [CMP_W-1:0] p1;
    p1 = CMP_W'(p) + CMP_W'(1);
    adv = (p1 >= len) ? '0 : p1[PTR_W-1:0];
  endfunction

  // level event from the used count after the operation
  function automatic brpr_pkg::ev_e level_ev(input logic [CMP_W-1:0] u,
                                            input logic [CMP_W-1:0] len);
    if (u == len / brpr_pkg::HALF_DIV) begin
      level_ev = brpr_pkg::EV_HALF;
    end else if (u == '0) begin
      level_ev = brpr_pkg::EV_EMPTY;
    end else if (u >= len) begin
      level_ev = brpr_pkg::EV_FULL;
    end else begin
      level_ev = brpr_pkg::EV_NONE;
    end
  endfunction

  assign used_ext     = CMP_W'(used_r);
  assign peeked_ext   = CMP_W'(peeked_r);
  assign reserved_ext = CMP_W'(reserved_r);
  assign size_ok      = (in_word.size == cfg.block_size);
  assign op           = brpr_pkg::op_e'(in_word.op);

  // operation decode and next state
  always_comb begin
    read_ptr_nxt    = read_ptr_r;
    write_ptr_nxt   = write_ptr_r;
    peek_ptr_nxt    = peek_ptr_r;
    reserve_ptr_nxt = reserve_ptr_r;
    used_nxt        = used_r;
    peeked_nxt      = peeked_r;
    reserved_nxt    = reserved_r;
    res_ok          = 1'b0;
    res_nb          = 1'b0;
    slot_sel        = '0;
    ev              = brpr_pkg::EV_NONE;
    case (op)
      brpr_pkg::OP_PUSH: begin
        if (size_ok && reserved_r == '0) begin
          if (used_ext >= n_len) begin
            ev = brpr_pkg::EV_OVERFLOW;
          end else begin
            slot_sel        = write_ptr_r;
            write_ptr_nxt   = adv(write_ptr_r, n_len);
            reserve_ptr_nxt = adv(write_ptr_r, n_len);
            used_nxt        = used_r + 1'b1;
            res_ok          = 1'b1;
            ev              = level_ev(used_ext + CMP_W'(1), n_len);
          end
        end
      end
      brpr_pkg::OP_POP: begin
        if (size_ok && peeked_r == '0) begin
          if (used_r == '0) begin
            res_nb = 1'b1;
            ev     = brpr_pkg::EV_UNDERFLOW;
          end else begin
            slot_sel     = read_ptr_r;
            read_ptr_nxt = adv(read_ptr_r, n_len);
            peek_ptr_nxt = adv(read_ptr_r, n_len);
            used_nxt     = used_r - 1'b1;
            res_ok       = 1'b1;
            ev           = level_ev(used_ext - CMP_W'(1), n_len);
          end
        end
      end
      brpr_pkg::OP_PEEK: begin
        if (peeked_r < used_r) begin
          slot_sel     = peek_ptr_r;
          peek_ptr_nxt = adv(peek_ptr_r, n_len);
          peeked_nxt   = peeked_r + 1'b1;
          res_ok       = 1'b1;
        end else begin
          res_nb = 1'b1;
          ev     = brpr_pkg::EV_UNDERFLOW;
        end
      end
      brpr_pkg::OP_UNPEEK: begin
        peek_ptr_nxt = read_ptr_r;
        peeked_nxt   = '0;
        res_ok       = 1'b1;
      end
      brpr_pkg::OP_CONSUME: begin
        used_nxt     = (peeked_r > used_r) ? '0 : used_r - peeked_r;
        peeked_nxt   = '0;
        read_ptr_nxt = peek_ptr_r;
        res_ok       = 1'b1;
        ev           = level_ev((peeked_ext > used_ext) ? '0 : used_ext - peeked_ext,
                                n_len);
      end
      brpr_pkg::OP_RESERVE: begin
        if (used_ext < n_len && (n_len - used_ext) > reserved_ext) begin
          slot_sel        = reserve_ptr_r;
          reserve_ptr_nxt = adv(reserve_ptr_r, n_len);
          reserved_nxt    = reserved_r + 1'b1;
          res_ok          = 1'b1;
        end else begin
          ev = brpr_pkg::EV_OVERFLOW;
        end
      end
      brpr_pkg::OP_COMMIT: begin
        used_nxt      = used_r + reserved_r;
        reserved_nxt  = '0;
        write_ptr_nxt = reserve_ptr_r;
        res_ok        = 1'b1;
        ev            = level_ev(used_ext + reserved_ext, n_len);
      end
      brpr_pkg::OP_RELEASE: begin
        reserved_nxt    = '0;
        reserve_ptr_nxt = write_ptr_r;
        res_ok          = 1'b1;
      end
      default: begin
        res_ok = 1'b0;
      end
    endcase
  end

  // result fields narrowed to the port widths
  assign slot_ext     = CMP_W'(slot_sel);
  assign used_out_ext = CMP_W'(used_nxt);
  assign res = '{ok: res_ok, slot: slot_ext[5:0], null_block: res_nb, event_res: ev,
                 used_count: used_out_ext[6:0]};

  // state update on each processed word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      read_ptr_r    <= '0;
      write_ptr_r   <= '0;
      peek_ptr_r    <= '0;
      reserve_ptr_r <= '0;
      used_r        <= '0;
      peeked_r      <= '0;
      reserved_r    <= '0;
    end else if (fire) begin
      read_ptr_r    <= read_ptr_nxt;
      write_ptr_r   <= write_ptr_nxt;
      peek_ptr_r    <= peek_ptr_nxt;
      reserve_ptr_r <= reserve_ptr_nxt;
      used_r        <= used_nxt;
      peeked_r      <= peeked_nxt;
      reserved_r    <= reserved_nxt;
    end
  end

  assign push_ok = fire && op == brpr_pkg::OP_PUSH && res_ok;

  // peeked blocks never run ahead of committed blocks
  `BRPR_ASSERT(a_peek_le_used, peeked_r <= used_r, "peeked count exceeds used count")
  // committed plus reserved blocks stay within the ring capacity
  `BRPR_ASSERT(a_cap, used_ext + reserved_ext <= CMP_W'(MAX_BLOCKS), "ring capacity exceeded")
  // a successful push adds exactly one block
  `BRPR_ASSERT(a_push_inc, push_ok |=> used_r == $past(used_r) + 1'b1, "push count wrong")

endmodule

>>> src/block_ring_with_peek_and_reserve_top.sv
// top level of the block ring controller: handshake stages and config registers
// a word goes from the input register through the operation logic into the result register
// throughput: one word per cycle while out_ready does not stall the result register, set by
// the single-pass operation logic between the input register and the result register
// reset: synchronous active-low rst_n clears pointers, counts and valids,
// block_count returns to 64 and block_size to 512
module block_ring_with_peek_and_reserve_top #(
  parameter int MAX_BLOCKS = brpr_pkg::MAX_BLOCKS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  brpr_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output brpr_pkg::out_word_t out_word,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_data
);

  logic                s1_valid_r;
  brpr_pkg::in_word_t  s1_word_r;
  logic                out_valid_r;
  brpr_pkg::out_word_t out_word_r;
  brpr_pkg::cfg_t      cfg_r;
  brpr_pkg::out_word_t res;
  logic                s1_fire;

  // stage 1 moves on when the result register is free or being drained
  assign s1_fire   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || s1_fire;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.block_count <= brpr_pkg::BLOCK_COUNT_RST;
      cfg_r.block_size  <= brpr_pkg::BLOCK_SIZE_RST;
    end else if (cfg_valid) begin
      if (cfg_index == brpr_pkg::CFG_BLOCK_COUNT) begin
        cfg_r.block_count <= cfg_data[6:0];
      end else begin
        cfg_r.block_size <= cfg_data;
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_word_r <= in_word;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_word_r <= res;
    end
  end

  brpr_ctrl #(
    .MAX_BLOCKS(MAX_BLOCKS)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (s1_fire),
    .in_word (s1_word_r),
    .cfg     (cfg_r),
    .res     (res)
  );

endmodule

>>> verif/block_ring_with_peek_and_reserve_top_test.sv
// self-checking testbench of the block ring controller: directed table, then random op sequences
module block_ring_with_peek_and_reserve_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  brpr_pkg::in_word_t  in_word;
  logic                out_valid;
  logic                out_ready;
  brpr_pkg::out_word_t out_word;
  logic                cfg_valid;
  logic                cfg_ready;
  logic                cfg_index;
  logic [15:0]         cfg_data;

  block_ring_with_peek_and_reserve_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // clock
  always #5 clk = ~clk;

  // shadow copy of the ring controller state and registers
  logic [6:0]  ring_count;
  logic [15:0] ring_size;
  logic [5:0]  rd_ptr, wr_ptr, pk_ptr, rsv_ptr;
  logic [6:0]  used_cnt, peek_cnt, rsv_cnt;

  // result words owed by the block, oldest first
  brpr_pkg::out_word_t owed_words [$];
  int                  err_cnt = 0;
  int                  items_sent = 0;
  int                  in_gap_pct = 15;
  int                  out_stall_pct = 12;

  // one row of the directed table
  typedef struct {
    bit                  is_cfg;
    logic                cfg_idx;
    logic [15:0]         cfg_val;
    brpr_pkg::op_e       op;
    logic [15:0]         size;
    bit                  has_exp;
    brpr_pkg::out_word_t exp;
  } dir_row_t;

  dir_row_t dir_tab [$];

  // append one row to the directed table
  function automatic void add_row(dir_row_t d);
    dir_tab = {dir_tab, d};
  endfunction

  // effective ring length: 0 acts as 1, above the capacity clamps
  function automatic int ring_len();
    if (ring_count < 7'd1) return 1;
    if (int'(ring_count) > brpr_pkg::MAX_BLOCKS_DEF) return brpr_pkg::MAX_BLOCKS_DEF;
    return int'(ring_count);
  endfunction

  function automatic logic [5:0] ring_next(logic [5:0] p);
    return (int'(p) + 1 >= ring_len()) ? 6'd0 : p + 6'd1;
  endfunction

  // fill level event after a level-changing op
  function automatic brpr_pkg::ev_e level_event();
    int n;
    n = ring_len();
    if (int'(used_cnt) == n / brpr_pkg::HALF_DIV) return brpr_pkg::EV_HALF;
    if (used_cnt == 7'd0) return brpr_pkg::EV_EMPTY;
    if (int'(used_cnt) >= n) return brpr_pkg::EV_FULL;
    return brpr_pkg::EV_NONE;
  endfunction

  // apply one op to the shadow state and return the result word it yields
  function automatic brpr_pkg::out_word_t ring_apply_op(brpr_pkg::op_e op, logic [15:0] sz);
    brpr_pkg::out_word_t r;
    int                  n;
    n = ring_len();
    r = '0;
    r.event_res = brpr_pkg::EV_NONE;
    case (op)
      brpr_pkg::OP_PUSH: begin
        if (sz == ring_size && rsv_cnt == 7'd0) begin
          if (int'(used_cnt) >= n) begin
            r.event_res = brpr_pkg::EV_OVERFLOW;
          end else begin
            r.slot = wr_ptr;
            wr_ptr = ring_next(wr_ptr);
            used_cnt = used_cnt + 7'd1;
            rsv_ptr = wr_ptr;
            r.ok = 1'b1;
            r.event_res = level_event();
          end
        end
      end
      brpr_pkg::OP_POP: begin
        if (sz == ring_size && peek_cnt == 7'd0) begin
          if (used_cnt == 7'd0) begin
            r.null_block = 1'b1;
            r.event_res = brpr_pkg::EV_UNDERFLOW;
          end else begin
            r.slot = rd_ptr;
            rd_ptr = ring_next(rd_ptr);
            used_cnt = used_cnt - 7'd1;
            pk_ptr = rd_ptr;
            r.ok = 1'b1;
            r.event_res = level_event();
          end
        end
      end
      brpr_pkg::OP_PEEK: begin
        if (peek_cnt < used_cnt) begin
          r.slot = pk_ptr;
          pk_ptr = ring_next(pk_ptr);
          peek_cnt = peek_cnt + 7'd1;
          r.ok = 1'b1;
        end else begin
          r.null_block = 1'b1;
          r.event_res = brpr_pkg::EV_UNDERFLOW;
        end
      end
      brpr_pkg::OP_UNPEEK: begin
        pk_ptr = rd_ptr;
        peek_cnt = 7'd0;
        r.ok = 1'b1;
      end
      brpr_pkg::OP_CONSUME: begin
        used_cnt = (peek_cnt > used_cnt) ? 7'd0 : used_cnt - peek_cnt;
        peek_cnt = 7'd0;
        rd_ptr = pk_ptr;
        r.ok = 1'b1;
        r.event_res = level_event();
      end
      brpr_pkg::OP_RESERVE: begin
        if (int'(used_cnt) < n && n - int'(used_cnt) > int'(rsv_cnt)) begin
          r.slot = rsv_ptr;
          rsv_ptr = ring_next(rsv_ptr);
          rsv_cnt = rsv_cnt + 7'd1;
          r.ok = 1'b1;
        end else begin
          r.event_res = brpr_pkg::EV_OVERFLOW;
        end
      end
      brpr_pkg::OP_COMMIT: begin
        used_cnt = used_cnt + rsv_cnt;
        rsv_cnt = 7'd0;
        wr_ptr = rsv_ptr;
        r.ok = 1'b1;
        r.event_res = level_event();
      end
      default: begin
        rsv_cnt = 7'd0;
        rsv_ptr = wr_ptr;
        r.ok = 1'b1;
      end
    endcase
    r.used_count = used_cnt;
    return r;
  endfunction

  // directed table row builders
  function automatic dir_row_t op_row(brpr_pkg::op_e op, logic [15:0] sz);
    dir_row_t d;
    d = '{is_cfg: 1'b0, cfg_idx: 1'b0, cfg_val: 16'd0, op: op, size: sz,
          has_exp: 1'b0, exp: '0};
    return d;
  endfunction

  function automatic dir_row_t chk_row(brpr_pkg::op_e op, logic [15:0] sz, logic ok,
                                       logic [5:0] slot, logic nb, brpr_pkg::ev_e ev,
                                       logic [6:0] used);
    dir_row_t d;
    d = op_row(op, sz);
    d.has_exp = 1'b1;
    d.exp = '{ok: ok, slot: slot, null_block: nb, event_res: ev, used_count: used};
    return d;
  endfunction

  function automatic dir_row_t cfg_row(logic idx, logic [15:0] val);
    dir_row_t d;
    d = op_row(brpr_pkg::OP_UNPEEK, 16'd0);
    d.is_cfg = 1'b1;
    d.cfg_idx = idx;
    d.cfg_val = val;
    return d;
  endfunction

  // send one op word, optionally after an idle burst, and record what it owes
  task automatic drive_op(brpr_pkg::op_e op, logic [15:0] sz, bit has_exp,
                          brpr_pkg::out_word_t exp);
    brpr_pkg::out_word_t pred;
    brpr_pkg::out_word_t owed;
    if ($urandom_range(0, 99) < in_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= '{op: op, size: sz};
    do @(posedge clk); while (!in_ready);
    pred = ring_apply_op(op, sz);
    owed = has_exp ? exp : pred;
    owed_words = {owed_words, owed};
    items_sent++;
  endtask

  // register write, only once every owed word has come back
  task automatic write_reg(logic idx, logic [15:0] val);
    in_valid <= 1'b0;
    while (owed_words.size() != 0) @(posedge clk);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == brpr_pkg::CFG_BLOCK_COUNT) ring_count = val[6:0];
    else ring_size = val;
  endtask

  // mostly the configured size, sometimes anything
  function automatic logic [15:0] pick_size();
    if ($urandom_range(0, 99) < 95) return ring_size;
    return 16'($urandom_range(0, 65535));
  endfunction

  // one random op sequence: bursts, peek and reserve transactions, or noise
  task automatic random_burst();
    int  r;
    int  k;
    r = $urandom_range(0, 99);
    k = $urandom_range(1, ring_len() + 1);
    if (r < 30) begin
      repeat (k) drive_op(brpr_pkg::OP_PUSH, pick_size(), 1'b0, '0);
    end else if (r < 55) begin
      repeat (k) drive_op(brpr_pkg::OP_POP, pick_size(), 1'b0, '0);
    end else if (r < 68) begin
      repeat (k) drive_op(brpr_pkg::OP_PEEK, 16'($urandom), 1'b0, '0);
      drive_op(($urandom_range(0, 9) < 6) ? brpr_pkg::OP_CONSUME : brpr_pkg::OP_UNPEEK,
               16'($urandom), 1'b0, '0);
    end else if (r < 81) begin
      repeat (k) drive_op(brpr_pkg::OP_RESERVE, 16'($urandom), 1'b0, '0);
      drive_op(($urandom_range(0, 9) < 6) ? brpr_pkg::OP_COMMIT : brpr_pkg::OP_RELEASE,
               16'($urandom), 1'b0, '0);
    end else begin
      drive_op(brpr_pkg::op_e'($urandom_range(0, 7)),
               ($urandom_range(0, 1) == 0) ? ring_size : 16'($urandom), 1'b0, '0);
    end
  endtask

  // receiver stalls in random bursts
  initial begin
    out_ready <= 1'b1;
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 99) < out_stall_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  task automatic cmp_field(string name, int want, int got);
    if (want != got) begin
      err_cnt++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // result checker
  always @(posedge clk) begin : res_check
    brpr_pkg::out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (owed_words.size() == 0) begin
        err_cnt++;
        $display("%0t ns: unexpected word, expected none, actual %h", $time, out_word);
      end else begin
        want = owed_words.pop_front();
        cmp_field("ok", want.ok, out_word.ok);
        cmp_field("slot", want.slot, out_word.slot);
        cmp_field("null_block", want.null_block, out_word.null_block);
        cmp_field("event_res", want.event_res, out_word.event_res);
        cmp_field("used_count", want.used_count, out_word.used_count);
      end
    end
  end

  // run limit
  initial begin
    #(5_000_000);
    $display("block_ring_with_peek_and_reserve_top_test: done, errors");
    $finish;
  end

  // main stimulus
  initial begin
    int          ph;
    int          phase_end;
    int          cnt;
    logic [15:0] val;
    dir_row_t    row;

    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_word   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= brpr_pkg::CFG_BLOCK_COUNT;
    cfg_data  <= 16'd0;

    ring_count = brpr_pkg::BLOCK_COUNT_RST;
    ring_size  = brpr_pkg::BLOCK_SIZE_RST;
    rd_ptr = 6'd0; wr_ptr = 6'd0; pk_ptr = 6'd0; rsv_ptr = 6'd0;
    used_cnt = 7'd0; peek_cnt = 7'd0; rsv_cnt = 7'd0;

    // empty ring after reset, refusals, open peek and open reservation
    add_row(chk_row(brpr_pkg::OP_POP, 16'd512, 1'b0, 6'd0, 1'b1,
                    brpr_pkg::EV_UNDERFLOW, 7'd0));
    add_row(chk_row(brpr_pkg::OP_PEEK, 16'hFFFF, 1'b0, 6'd0, 1'b1,
                    brpr_pkg::EV_UNDERFLOW, 7'd0));
    add_row(chk_row(brpr_pkg::OP_PUSH, 16'd511, 1'b0, 6'd0, 1'b0,
                    brpr_pkg::EV_NONE, 7'd0));
    add_row(chk_row(brpr_pkg::OP_PUSH, 16'd512, 1'b1, 6'd0, 1'b0,
                    brpr_pkg::EV_NONE, 7'd1));
    add_row(chk_row(brpr_pkg::OP_RESERVE, 16'd0, 1'b1, 6'd1, 1'b0,
                    brpr_pkg::EV_NONE, 7'd1));
    add_row(chk_row(brpr_pkg::OP_PUSH, 16'd512, 1'b0, 6'd0, 1'b0,
                    brpr_pkg::EV_NONE, 7'd1));
    add_row(chk_row(brpr_pkg::OP_COMMIT, 16'd0, 1'b1, 6'd0, 1'b0,
                    brpr_pkg::EV_NONE, 7'd2));
    add_row(chk_row(brpr_pkg::OP_PEEK, 16'd0, 1'b1, 6'd0, 1'b0,
                    brpr_pkg::EV_NONE, 7'd2));
    add_row(chk_row(brpr_pkg::OP_POP, 16'd512, 1'b0, 6'd0, 1'b0,
                    brpr_pkg::EV_NONE, 7'd2));
    add_row(chk_row(brpr_pkg::OP_UNPEEK, 16'd0, 1'b1, 6'd0, 1'b0,
                    brpr_pkg::EV_NONE, 7'd2));
    add_row(op_row(brpr_pkg::OP_PEEK, 16'd0));
    add_row(op_row(brpr_pkg::OP_CONSUME, 16'd0));
    add_row(op_row(brpr_pkg::OP_RELEASE, 16'd0));
    // one-slot ring with pointers past its end
    add_row(cfg_row(brpr_pkg::CFG_BLOCK_COUNT, 16'd1));
    add_row(op_row(brpr_pkg::OP_PUSH, 16'd512));
    add_row(op_row(brpr_pkg::OP_POP, 16'd512));
    add_row(op_row(brpr_pkg::OP_PUSH, 16'd512));
    add_row(op_row(brpr_pkg::OP_PUSH, 16'd512));
    add_row(op_row(brpr_pkg::OP_RESERVE, 16'd0));
    add_row(op_row(brpr_pkg::OP_COMMIT, 16'd0));
    // zero count acts as one, oversize count clamps to capacity
    add_row(cfg_row(brpr_pkg::CFG_BLOCK_COUNT, 16'd0));
    add_row(op_row(brpr_pkg::OP_POP, 16'd512));
    add_row(op_row(brpr_pkg::OP_PUSH, 16'd512));
    add_row(cfg_row(brpr_pkg::CFG_BLOCK_COUNT, 16'hFFFF));
    // size extremes
    add_row(cfg_row(brpr_pkg::CFG_BLOCK_SIZE, 16'hFFFF));
    add_row(op_row(brpr_pkg::OP_PUSH, 16'hFFFF));
    add_row(op_row(brpr_pkg::OP_POP, 16'h0000));
    add_row(cfg_row(brpr_pkg::CFG_BLOCK_SIZE, 16'd1));
    add_row(op_row(brpr_pkg::OP_PUSH, 16'd1));
    add_row(op_row(brpr_pkg::OP_POP, 16'd1));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    foreach (dir_tab[i]) begin
      row = dir_tab[i];
      if (row.is_cfg) write_reg(row.cfg_idx, row.cfg_val);
      else drive_op(row.op, row.size, row.has_exp, row.exp);
    end

    // random phases, each with its own ring length and block size
    for (ph = 0; ph < 14; ph++) begin
      case (ph % 7)
        0:       cnt = 1;
        1:       cnt = 64;
        2:       cnt = 0;
        3:       cnt = 2;
        4:       cnt = $urandom_range(65, 127);
        default: cnt = $urandom_range(3, 12);
      endcase
      val = 16'($urandom);
      val[6:0] = 7'(cnt);
      write_reg(brpr_pkg::CFG_BLOCK_COUNT, val);
      case (ph % 4)
        1:       val = 16'hFFFF;
        2:       val = 16'd1;
        default: val = 16'($urandom_range(1, 65535));
      endcase
      write_reg(brpr_pkg::CFG_BLOCK_SIZE, val);

      // last part of the run has no idling, some middle phases neither
      in_gap_pct    = (ph >= 12 || ph % 5 == 2) ? 0 : 15;
      out_stall_pct = (ph >= 12 || ph % 5 == 3) ? 0 : 12;

      phase_end = items_sent + 85;
      while (items_sent < phase_end) random_burst();
    end

    // drain
    in_valid <= 1'b0;
    while (owed_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (err_cnt == 0) begin
      $display("block_ring_with_peek_and_reserve_top_test: done, clean");
    end else begin
      $display("block_ring_with_peek_and_reserve_top_test: done, errors");
    end
    $finish;
  end

endmodule
